// ===== hdl/cdtc_pkg.sv =====
// shared types, constants and keyword tables for the token checker
package cdtc_pkg;

    localparam int unsigned NUM_KW    = 5;
    localparam int unsigned LEN_W     = 7;
    localparam int unsigned VAL_W     = 17;
    localparam logic [6:0]  LEN_SAT   = 7'd127;
    localparam logic [16:0] VAL_SAT   = 17'h1FFFF;
    localparam logic [16:0] NUM_MAX   = 17'd65535;
    localparam logic [6:0]  NUM_LEN_MAX = 7'd31;
    localparam logic [6:0]  NAME_LEN_LIMIT = 7'd63;

    // keyword slots in the word flags
    localparam int unsigned KW_COLON = 0;
    localparam int unsigned KW_SEMI  = 1;
    localparam int unsigned KW_IF    = 2;
    localparam int unsigned KW_ELSE  = 3;
    localparam int unsigned KW_THEN  = 4;

    // level mark bits
    localparam int unsigned MARK_ELSE = 0;
    localparam int unsigned MARK_TERM = 1;

    typedef enum logic [2:0] {
        KIND_COLON   = 3'd0,
        KIND_NAME    = 3'd1,
        KIND_NUMBER  = 3'd2,
        KIND_SEMI    = 3'd3,
        KIND_IF      = 3'd4,
        KIND_ELSE    = 3'd5,
        KIND_THEN    = 3'd6,
        KIND_VERDICT = 3'd7
    } kind_t;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_DEFNAME,
        ACT_COLON,
        ACT_SEMI,
        ACT_IF,
        ACT_ELSE,
        ACT_THEN,
        ACT_TERM
    } act_t;

    typedef struct packed {
        logic                active;
        logic [31:0]         start;
        logic [LEN_W-1:0]    len;
        logic                sign;
        logic                minus;
        logic                digits;
        logic                namech;
        logic                namestart;
        logic [NUM_KW-1:0]   kw;
        logic [VAL_W-1:0]    value;
    } word_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] pos;
        logic [5:0]  len;
        logic [15:0] num;
        logic        ok;
        logic        last;
    } tok_t;

    function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [1:0] i);
        logic [7:0] c;
        c = 8'h00;
        case (k)
            3'd0: c = (i == 2'd0) ? 8'h3A : 8'h00;
            3'd1: c = (i == 2'd0) ? 8'h3B : 8'h00;
            3'd2:
            begin
                case (i)
                    2'd0: c = 8'h49;
                    2'd1: c = 8'h46;
                    default: c = 8'h00;
                endcase
            end
            3'd3:
            begin
                case (i)
                    2'd0: c = 8'h45;
                    2'd1: c = 8'h4C;
                    2'd2: c = 8'h53;
                    default: c = 8'h45;
                endcase
            end
            3'd4:
            begin
                case (i)
                    2'd0: c = 8'h54;
                    2'd1: c = 8'h48;
                    2'd2: c = 8'h45;
                    default: c = 8'h4E;
                endcase
            end
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [2:0] kw_len(input logic [2:0] k);
        logic [2:0] n;
        case (k)
            3'd0: n = 3'd1;
            3'd1: n = 3'd1;
            3'd2: n = 3'd2;
            3'd3: n = 3'd4;
            3'd4: n = 3'd4;
            default: n = 3'd0;
        endcase
        return n;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_nstart(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
               c == 8'h5F || c == 8'h2D;
    endfunction

endpackage

// ===== hdl/cdtc_if.sv =====
// valid/ready channel interfaces for source bytes and token words
interface cdtc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] src_byte;
    logic       end_of_source;

    modport source (output valid, output src_byte, output end_of_source, input ready);
    modport sink   (input valid, input src_byte, input end_of_source, output ready);
endinterface

interface cdtc_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  token_kind;
    logic [31:0] token_offset;
    logic [5:0]  token_len;
    logic [15:0] number_value;
    logic        verdict_ok;
    logic        last_result;

    modport source (output valid, output token_kind, output token_offset, output token_len,
                    output number_value, output verdict_ok, output last_result,
                    input ready);
    modport sink   (input valid, input token_kind, input token_offset, input token_len,
                    input number_value, input verdict_ok, input last_result,
                    output ready);
endinterface

// ===== hdl/colon_definition_token_checker_core.sv =====
// top level: definition and nesting checker around the level mark ram
//
//  channel  | dir | words                      | payload
//  src_ch   | in  | one source byte            | src_byte, end_of_source
//  tok_ch   | out | token or verdict record    | kind, pos, len, value, ok, last
//
// one byte is taken every cycle while the result queue has room for two words.
// the level marks below the innermost if live in a ram prefetched at depth-1 by a
// registered read; the innermost mark sits in a register, a same-entry write is forwarded.
// the final byte yields up to two words (token, verdict) and returns all state to reset.
// reset needs no clearing pass: every mark read was first written by a push.
module colon_definition_token_checker_core #(
    parameter int unsigned STACK_DEPTH = 1024,
    parameter int unsigned MAX_TOKENS  = 256,
    parameter int unsigned MAX_NAME    = 63
) (
    input  logic        clk,
    input  logic        rst_n,
    cdtc_in_if.sink     src_ch,
    cdtc_out_if.source  tok_ch
);

    localparam int unsigned AW = $clog2(STACK_DEPTH + 1);
    localparam int unsigned TW = $clog2(MAX_TOKENS + 1);

    logic acc;
    logic room;
    logic fin;
    cdtc_pkg::word_t wd;

    logic          failed_reg, failed_next;
    logic          inside_reg, inside_next;
    logic          expect_reg, expect_next;
    logic [AW-1:0] depth_reg, depth_next;
    logic [1:0]    top_reg, top_next;
    logic [TW-1:0] tokens_reg, tokens_next;
    logic          fwd_hit_reg;
    logic [1:0]    fwd_data_reg;

    logic [1:0]    ram_rdata;
    logic [1:0]    below;
    logic          we;
    logic [AW-1:0] raddr;

    cdtc_pkg::act_t  act;
    cdtc_pkg::kind_t kind;
    logic [6:0]      elen;
    logic            rule_fail;
    logic            emit_fail;
    logic            do_act;
    logic [4:0]      kw_hit;
    logic            numeric;
    logic            num_ok;
    logic            vdt_ok;
    cdtc_pkg::tok_t  tok;
    cdtc_pkg::tok_t  vdt;

    assign acc = src_ch.valid && src_ch.ready;
    assign src_ch.ready = room;

    cdtc_lexer u_lexer (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (acc),
        .src_byte (src_ch.src_byte),
        .last     (src_ch.end_of_source),
        .fin      (fin),
        .fin_word (wd)
    );

    always_comb
    begin
        below = fwd_hit_reg ? fwd_data_reg : ram_rdata;
        for (int k = 0; k < cdtc_pkg::NUM_KW; k++)
        begin
            kw_hit[k] = wd.kw[k] && (wd.len == {4'd0, cdtc_pkg::kw_len(3'(k))});
        end
        numeric = wd.digits && !(wd.len == 7'd1 && wd.sign);
        num_ok  = numeric && wd.len <= cdtc_pkg::NUM_LEN_MAX && wd.value <= cdtc_pkg::NUM_MAX &&
                  (!wd.minus || wd.value == '0);

        act = cdtc_pkg::ACT_NONE;
        kind = cdtc_pkg::KIND_NAME;
        elen = wd.len;
        rule_fail = 1'b0;
        if (expect_reg)
        begin
            if (!(wd.namestart && wd.namech)) rule_fail = 1'b1;
            else act = cdtc_pkg::ACT_DEFNAME;
        end
        else if (kw_hit[cdtc_pkg::KW_COLON])
        begin
            kind = cdtc_pkg::KIND_COLON;
            if (inside_reg) rule_fail = 1'b1;
            else act = cdtc_pkg::ACT_COLON;
        end
        else if (!inside_reg || 32'(depth_reg) > STACK_DEPTH)
        begin
            rule_fail = 1'b1;
        end
        else if (kw_hit[cdtc_pkg::KW_SEMI])
        begin
            kind = cdtc_pkg::KIND_SEMI;
            if (depth_reg != '0) rule_fail = 1'b1;
            else act = cdtc_pkg::ACT_SEMI;
        end
        else if (kw_hit[cdtc_pkg::KW_IF])
        begin
            kind = cdtc_pkg::KIND_IF;
            if (32'(depth_reg) >= STACK_DEPTH) rule_fail = 1'b1;
            else act = cdtc_pkg::ACT_IF;
        end
        else if (kw_hit[cdtc_pkg::KW_ELSE])
        begin
            kind = cdtc_pkg::KIND_ELSE;
            if (depth_reg == '0 || top_reg[cdtc_pkg::MARK_ELSE] ||
                !top_reg[cdtc_pkg::MARK_TERM]) rule_fail = 1'b1;
            else act = cdtc_pkg::ACT_ELSE;
        end
        else if (kw_hit[cdtc_pkg::KW_THEN])
        begin
            kind = cdtc_pkg::KIND_THEN;
            if (depth_reg == '0 || !top_reg[cdtc_pkg::MARK_TERM]) rule_fail = 1'b1;
            else act = cdtc_pkg::ACT_THEN;
        end
        else if (num_ok)
        begin
            kind = cdtc_pkg::KIND_NUMBER;
            elen = '0;
            act  = cdtc_pkg::ACT_TERM;
        end
        else if (numeric || wd.len > cdtc_pkg::NAME_LEN_LIMIT || !wd.namech)
        begin
            rule_fail = 1'b1;
        end
        else
        begin
            act = cdtc_pkg::ACT_TERM;
        end

        emit_fail = tokens_reg >= TW'(MAX_TOKENS) ||
                    (kind != cdtc_pkg::KIND_NUMBER && 32'(elen) > MAX_NAME);
        do_act = fin && !failed_reg && act != cdtc_pkg::ACT_NONE && !emit_fail;

        failed_next = failed_reg;
        inside_next = inside_reg;
        expect_next = expect_reg;
        depth_next  = depth_reg;
        top_next    = top_reg;
        tokens_next = tokens_reg;
        we          = 1'b0;
        if (acc)
        begin
            if (fin && !failed_reg && (rule_fail || (act != cdtc_pkg::ACT_NONE && emit_fail)))
            begin
                failed_next = 1'b1;
            end
            if (do_act)
            begin
                tokens_next = tokens_reg + TW'(1);
                case (act)
                    cdtc_pkg::ACT_DEFNAME:
                    begin
                        expect_next = 1'b0;
                        inside_next = 1'b1;
                        depth_next  = '0;
                    end
                    cdtc_pkg::ACT_COLON: expect_next = 1'b1;
                    cdtc_pkg::ACT_SEMI:  inside_next = 1'b0;
                    cdtc_pkg::ACT_IF:
                    begin
                        we         = 1'b1;
                        depth_next = depth_reg + AW'(1);
                        top_next   = 2'b00;
                    end
                    cdtc_pkg::ACT_ELSE: top_next = 2'b01;
                    cdtc_pkg::ACT_THEN:
                    begin
                        depth_next = depth_reg - AW'(1);
                        top_next   = (depth_reg != AW'(1)) ? (below | 2'b10) : 2'b00;
                    end
                    cdtc_pkg::ACT_TERM: top_next = top_reg | 2'b10;
                    default: top_next = top_reg;
                endcase
            end
        end

        vdt_ok = !failed_next && !inside_next && !expect_next && depth_next == '0;
        if (acc && src_ch.end_of_source)
        begin
            failed_next = 1'b0;
            inside_next = 1'b0;
            expect_next = 1'b0;
            depth_next  = '0;
            top_next    = 2'b00;
            tokens_next = '0;
        end

        // prefetch the mark one level below the next depth
        raddr = (depth_next == '0) ? '0 : depth_next - AW'(1);

        tok.kind = kind;
        tok.pos  = wd.start;
        tok.len  = elen[5:0];
        tok.num  = (kind == cdtc_pkg::KIND_NUMBER) ? wd.value[15:0] : 16'd0;
        tok.ok   = 1'b0;
        tok.last = 1'b0;

        vdt.kind = cdtc_pkg::KIND_VERDICT;
        vdt.pos  = '0;
        vdt.len  = '0;
        vdt.num  = '0;
        vdt.ok   = vdt_ok;
        vdt.last = 1'b1;
    end

    cdtc_ram #(
        .WIDTH (2),
        .DEPTH (STACK_DEPTH + 1)
    ) u_marks (
        .clk   (clk),
        .we    (we),
        .waddr (depth_reg),
        .wdata (top_reg),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    cdtc_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_tok (acc && do_act),
        .tok      (tok),
        .push_vdt (acc && src_ch.end_of_source),
        .vdt      (vdt),
        .room     (room),
        .tok_ch   (tok_ch)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            failed_reg  <= 1'b0;
            inside_reg  <= 1'b0;
            expect_reg  <= 1'b0;
            depth_reg   <= '0;
            top_reg     <= 2'b00;
            tokens_reg  <= '0;
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            failed_reg  <= failed_next;
            inside_reg  <= inside_next;
            expect_reg  <= expect_next;
            depth_reg   <= depth_next;
            top_reg     <= top_next;
            tokens_reg  <= tokens_next;
            fwd_hit_reg <= we && (depth_reg == raddr);
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= top_reg;
    end

`ifndef NO_ASSERTIONS
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(depth_reg) <= STACK_DEPTH)
        else $error("nesting depth beyond stack");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        acc && src_ch.end_of_source |=> depth_reg == '0 && !failed_reg && !inside_reg)
        else $error("state not cleared after final byte");

    a_mode_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(inside_reg && expect_reg))
        else $error("pending name inside a definition");
`endif

endmodule

// ===== hdl/cdtc_ram.sv =====
// generic single-write, single-read ram with registered read (read-old on collision)
module cdtc_ram #(
    parameter int unsigned WIDTH = 2,
    parameter int unsigned DEPTH = 1025
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/cdtc_lexer.sv =====
// word accumulator: splits bytes on whitespace and tracks class flags and value
module cdtc_lexer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          src_byte,
    input  logic                last,
    output logic                fin,
    output cdtc_pkg::word_t     fin_word
);

    cdtc_pkg::word_t word_reg, word_next, add_w;
    logic [31:0] pos_reg, pos_next;
    logic        sp;
    logic        dig;
    logic        nch;
    logic [20:0] prod;
    logic [1:0]  idx;

    always_comb
    begin
        sp   = cdtc_pkg::is_space(src_byte);
        dig  = cdtc_pkg::is_digit(src_byte);
        nch  = cdtc_pkg::is_nstart(src_byte) || dig;
        add_w = word_reg;
        if (!word_reg.active)
        begin
            add_w.active    = 1'b1;
            add_w.start     = pos_reg;
            add_w.len       = '0;
            add_w.value     = '0;
            add_w.sign      = (src_byte == 8'h2B) || (src_byte == 8'h2D);
            add_w.minus     = (src_byte == 8'h2D);
            add_w.digits    = add_w.sign || dig;
            add_w.namestart = cdtc_pkg::is_nstart(src_byte);
            add_w.namech    = nch;
            add_w.kw        = '1;
        end
        else
        begin
            add_w.digits = word_reg.digits && dig;
            add_w.namech = word_reg.namech && nch;
        end
        // only the first four bytes can still match a keyword
        idx = add_w.len[1:0];
        for (int k = 0; k < cdtc_pkg::NUM_KW; k++)
        begin
            if (add_w.len >= {4'd0, cdtc_pkg::kw_len(3'(k))} ||
                src_byte != cdtc_pkg::kw_char(3'(k), idx))
            begin
                add_w.kw[k] = 1'b0;
            end
        end
        prod = 21'(add_w.value) * 21'd10 + 21'(src_byte - 8'h30);
        if (dig)
        begin
            add_w.value = (prod > 21'(cdtc_pkg::VAL_SAT)) ? cdtc_pkg::VAL_SAT : prod[16:0];
        end
        if (add_w.len < cdtc_pkg::LEN_SAT)
        begin
            add_w.len = add_w.len + 7'd1;
        end

        fin      = sp ? word_reg.active : last;
        fin_word = sp ? word_reg : add_w;

        word_next = word_reg;
        pos_next  = pos_reg;
        if (accept)
        begin
            pos_next = pos_reg + 32'd1;
            if (sp)
            begin
                word_next.active = 1'b0;
            end
            else
            begin
                word_next = add_w;
            end
            if (last)
            begin
                word_next = '0;
                pos_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= '0;
            pos_reg  <= '0;
        end
        else
        begin
            word_reg <= word_next;
            pos_reg  <= pos_next;
        end
    end

endmodule

// ===== hdl/cdtc_outq.sv =====
// four-word result queue taking up to two words per cycle
module cdtc_outq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_tok,
    input  cdtc_pkg::tok_t  tok,
    input  logic            push_vdt,
    input  cdtc_pkg::tok_t  vdt,
    output logic            room,
    cdtc_out_if.source      tok_ch
);

    cdtc_pkg::tok_t q_reg [4];
    logic [1:0] wptr_reg, wptr_next;
    logic [1:0] rptr_reg, rptr_next;
    logic [2:0] count_reg, count_next;
    logic       pop;
    logic [1:0] n_push;
    cdtc_pkg::tok_t first;
    cdtc_pkg::tok_t head;

    always_comb
    begin
        head  = q_reg[rptr_reg];
        pop   = tok_ch.valid && tok_ch.ready;
        n_push = {1'b0, push_tok} + {1'b0, push_vdt};
        first = push_tok ? tok : vdt;
        wptr_next  = wptr_reg + n_push;
        rptr_next  = rptr_reg + {1'b0, pop};
        count_next = count_reg + {1'b0, n_push} - {2'b0, pop};
        room = count_reg <= 3'd2;
    end

    assign tok_ch.valid        = count_reg != 3'd0;
    assign tok_ch.token_kind   = head.kind;
    assign tok_ch.token_offset = head.pos;
    assign tok_ch.token_len    = head.len;
    assign tok_ch.number_value = head.num;
    assign tok_ch.verdict_ok   = head.ok;
    assign tok_ch.last_result  = head.last;

    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
        begin
            q_reg[wptr_reg] <= first;
        end
        if (n_push == 2'd2)
        begin
            q_reg[wptr_reg + 2'd1] <= vdt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

endmodule
